FILE: design/wfc_pkg.sv
// Shared constants, types and the quarter-wave sine table for the windowed Fourier block.
package wfc_pkg;

    localparam int MAX_WINDOW      = 1024;
    localparam int MAX_FREQUENCIES = 64;
    localparam int SINE_TABLE_BITS = 10;

    localparam int RING_AW  = $clog2(MAX_WINDOW);
    localparam int FREQ_AW  = $clog2(MAX_FREQUENCIES);
    localparam int QBITS    = SINE_TABLE_BITS - 2;
    localparam int QLEN     = 1 << QBITS;

    localparam int LEN_W    = 11;
    localparam int FCNT_W   = 7;
    localparam int ACC_W    = 64;
    localparam int XW_W     = 33;
    localparam int TRIG_W   = 17;
    localparam int PROD_W   = XW_W + TRIG_W;

    localparam logic [LEN_W-1:0]  WINDOW_RESET = LEN_W'(1024);
    localparam logic [LEN_W-1:0]  HOP_RESET    = LEN_W'(512);
    localparam logic [FCNT_W-1:0] FREQS_RESET  = FCNT_W'(32);

    localparam longint POLY_C1 = 64'sd1686629713;
    localparam longint POLY_C3 = 64'sd693598668;
    localparam longint POLY_C5 = 64'sd85569306;
    localparam longint POLY_C7 = 64'sd5026995;
    localparam longint POLY_C9 = 64'sd172272;

    typedef enum logic [1:0] {
        OP_SAMPLE = 2'd0,
        OP_WEIGHT = 2'd1,
        OP_INC    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        CFG_WINDOW = 2'd0,
        CFG_HOP    = 2'd1,
        CFG_FREQS  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic               ring_we;
        logic               weight_we;
        logic               inc_we;
        logic               inc_load;
        logic               step;
        logic               result_load;
        logic               last;
        logic [RING_AW-1:0] ring_waddr;
        logic [RING_AW-1:0] ring_raddr;
        logic [RING_AW-1:0] weight_raddr;
        logic [FREQ_AW-1:0] freq;
    } cmd_t;

    typedef struct packed {
        logic busy;
    } status_t;

    typedef logic [15:0] qsin_t [0:QLEN];

    // First quarter of the sine, odd degree-9 polynomial in Q30, rounded to Q15.
    function automatic qsin_t build_qsin();
        qsin_t  tab;
        longint u;
        longint u2;
        longint t;
        longint s;
        longint r;
        for (int k = 0; k <= QLEN; k++) begin
            u  = longint'(k) <<< (30 - QBITS);
            u2 = (u * u) >>> 30;
            t  = POLY_C7 - ((u2 * POLY_C9) >>> 30);
            t  = POLY_C5 - ((u2 * t) >>> 30);
            t  = POLY_C3 - ((u2 * t) >>> 30);
            t  = POLY_C1 - ((u2 * t) >>> 30);
            s  = (u * t) >>> 30;
            r  = (s + 64'sd16384) >>> 15;
            if (r > 64'sd32768) begin
                r = 64'sd32768;
            end
            tab[k] = 16'(r);
        end
        return tab;
    endfunction

    localparam qsin_t QSIN = build_qsin();

    // Full-cycle sine from the top bits of a phase, via quarter-wave symmetry.
    function automatic logic signed [TRIG_W-1:0] trig_q15(logic [SINE_TABLE_BITS-1:0] idx);
        logic [1:0]        quad;
        logic [QBITS:0]    k;
        logic [TRIG_W-1:0] mag;
        quad = idx[SINE_TABLE_BITS-1 -: 2];
        k    = {1'b0, idx[QBITS-1:0]};
        if (quad[0]) begin
            k = (QBITS+1)'(QLEN) - k;
        end
        mag = {1'b0, QSIN[k]};
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

FILE: design/wfc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wfc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: design/wfc_datapath.sv
// Datapath: sample, weight and increment memories, phase, MAC pipeline, rounding.
module wfc_datapath (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  wfc_pkg::cmd_t            cmd,
    output wfc_pkg::status_t         status,
    input  logic [9:0]               s_table_index,
    input  logic signed [15:0]       s_sample,
    input  logic [31:0]              s_table_value,
    output logic [5:0]               m_frequency_index,
    output logic signed [31:0]       m_real_part,
    output logic signed [31:0]       m_imag_part,
    output logic                     m_last
);

    logic [15:0] ring_rdata;
    logic [15:0] wt_rdata;
    logic [31:0] inc_rdata;
    logic [15:0] wt_wdata;

    logic [31:0] inc_reg;
    logic [31:0] phase_reg;

    logic                                     s1_valid_reg;
    logic [wfc_pkg::SINE_TABLE_BITS-1:0]      s1_idx_reg;
    logic                                     s2_valid_reg;
    logic signed [wfc_pkg::XW_W-1:0]          s2_xw_reg;
    logic signed [wfc_pkg::TRIG_W-1:0]        s2_cos_reg;
    logic signed [wfc_pkg::TRIG_W-1:0]        s2_sin_reg;
    logic                                     s3_valid_reg;
    logic signed [wfc_pkg::PROD_W-1:0]        s3_re_reg;
    logic signed [wfc_pkg::PROD_W-1:0]        s3_im_reg;
    logic signed [wfc_pkg::ACC_W-1:0]         acc_re_reg;
    logic signed [wfc_pkg::ACC_W-1:0]         acc_im_reg;

    logic [wfc_pkg::SINE_TABLE_BITS-1:0]      cos_idx;
    logic signed [wfc_pkg::XW_W-1:0]          xw_next;
    logic signed [wfc_pkg::PROD_W-1:0]        re_next;
    logic signed [wfc_pkg::PROD_W-1:0]        im_next;

    assign wt_wdata = (|s_table_value[31:16]) ? 16'hFFFF : s_table_value[15:0];

    wfc_ram #(.WIDTH(16), .DEPTH(wfc_pkg::MAX_WINDOW)) u_ring (
        .aclk (aclk), .we (cmd.ring_we), .waddr (cmd.ring_waddr),
        .wdata (s_sample), .raddr (cmd.ring_raddr), .rdata (ring_rdata)
    );

    wfc_ram #(.WIDTH(16), .DEPTH(wfc_pkg::MAX_WINDOW)) u_weight (
        .aclk (aclk), .we (cmd.weight_we), .waddr (s_table_index[wfc_pkg::RING_AW-1:0]),
        .wdata (wt_wdata), .raddr (cmd.weight_raddr), .rdata (wt_rdata)
    );

    wfc_ram #(.WIDTH(32), .DEPTH(wfc_pkg::MAX_FREQUENCIES)) u_inc (
        .aclk (aclk), .we (cmd.inc_we), .waddr (s_table_index[wfc_pkg::FREQ_AW-1:0]),
        .wdata (s_table_value), .raddr (cmd.freq), .rdata (inc_rdata)
    );

    assign cos_idx = s1_idx_reg + wfc_pkg::SINE_TABLE_BITS'(wfc_pkg::QLEN);
    assign xw_next = wfc_pkg::XW_W'($signed(ring_rdata)) *
                     wfc_pkg::XW_W'($signed({1'b0, wt_rdata}));
    assign re_next = wfc_pkg::PROD_W'(s2_xw_reg) * wfc_pkg::PROD_W'(s2_cos_reg);
    assign im_next = wfc_pkg::PROD_W'(s2_xw_reg) * wfc_pkg::PROD_W'(s2_sin_reg);

    assign status.busy = s1_valid_reg | s2_valid_reg | s3_valid_reg;

    // Round to Q15 (add half, floor shift by 30) and saturate to 32 bits.
    function automatic logic signed [31:0] round_sat(logic signed [wfc_pkg::ACC_W-1:0] acc);
        logic signed [wfc_pkg::ACC_W-1:0] sum;
        logic signed [33:0]               sh;
        sum = acc + 64'sd536870912;
        sh  = sum[63:30];
        if (sh[33:31] == 3'b000 || sh[33:31] == 3'b111) begin
            return sh[31:0];
        end
        return sh[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.step;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.inc_load) begin
            inc_reg    <= inc_rdata;
            phase_reg  <= '0;
            acc_re_reg <= '0;
            acc_im_reg <= '0;
        end else begin
            if (cmd.step) begin
                phase_reg <= phase_reg + inc_reg;
            end
            if (s3_valid_reg) begin
                acc_re_reg <= acc_re_reg + wfc_pkg::ACC_W'(s3_re_reg);
                acc_im_reg <= acc_im_reg + wfc_pkg::ACC_W'(s3_im_reg);
            end
        end
        s1_idx_reg <= phase_reg[31 -: wfc_pkg::SINE_TABLE_BITS];
        s2_xw_reg  <= xw_next;
        s2_cos_reg <= wfc_pkg::trig_q15(cos_idx);
        s2_sin_reg <= wfc_pkg::trig_q15(s1_idx_reg);
        s3_re_reg  <= re_next;
        s3_im_reg  <= im_next;
        if (cmd.result_load) begin
            m_frequency_index <= cmd.freq;
            m_real_part       <= round_sat(acc_re_reg);
            m_imag_part       <= round_sat(acc_im_reg);
            m_last            <= cmd.last;
        end
    end

endmodule

FILE: design/wfc_ctrl.sv
// Controller: config registers, sample/hop counting and the frame sequencer.
module wfc_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [1:0]               s_operation,
    input  logic [9:0]               s_table_index,
    output logic                     m_valid,
    input  logic                     m_ready,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [10:0]              cfg_data,
    output wfc_pkg::cmd_t            cmd,
    input  wfc_pkg::status_t         status
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_INC_RD = 7'b0000010,
        ST_INC_LD = 7'b0000100,
        ST_RUN    = 7'b0001000,
        ST_DRAIN  = 7'b0010000,
        ST_RESULT = 7'b0100000,
        ST_OUT    = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [wfc_pkg::LEN_W-1:0]   window_reg, hop_reg;
    logic [wfc_pkg::FCNT_W-1:0]  freqs_reg;
    logic [wfc_pkg::RING_AW-1:0] wp_reg, wp_next;
    logic [wfc_pkg::LEN_W-1:0]   seen_reg, seen_next;
    logic [wfc_pkg::LEN_W-1:0]   hop_cnt_reg, hop_cnt_next;
    logic [wfc_pkg::RING_AW-1:0] start_reg, start_next;
    logic [wfc_pkg::LEN_W-1:0]   n_reg, n_next;
    logic [wfc_pkg::FREQ_AW-1:0] k_reg, k_next;

    logic [wfc_pkg::LEN_W-1:0]   eff_len, eff_hop;
    logic [wfc_pkg::FCNT_W-1:0]  eff_nf;
    logic                        accept, is_sample, trigger, last_k;

    assign eff_len = (window_reg == '0) ? wfc_pkg::LEN_W'(1) :
                     (window_reg > wfc_pkg::LEN_W'(wfc_pkg::MAX_WINDOW)) ?
                     wfc_pkg::LEN_W'(wfc_pkg::MAX_WINDOW) : window_reg;
    assign eff_hop = (hop_reg == '0) ? wfc_pkg::LEN_W'(1) : hop_reg;
    assign eff_nf  = (freqs_reg == '0) ? wfc_pkg::FCNT_W'(1) :
                     (freqs_reg > wfc_pkg::FCNT_W'(wfc_pkg::MAX_FREQUENCIES)) ?
                     wfc_pkg::FCNT_W'(wfc_pkg::MAX_FREQUENCIES) : freqs_reg;

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;
    assign is_sample = accept && (s_operation == wfc_pkg::OP_SAMPLE);
    assign last_k    = (wfc_pkg::FCNT_W'(k_reg) + wfc_pkg::FCNT_W'(1)) == eff_nf;

    // Frame trigger: first full window, then every hop.
    always_comb begin
        seen_next    = seen_reg;
        hop_cnt_next = hop_cnt_reg;
        trigger      = 1'b0;
        wp_next      = wp_reg;
        if (is_sample) begin
            wp_next = wp_reg + 1'b1;
            if (seen_reg < eff_len) begin
                seen_next = seen_reg + 1'b1;
                if (seen_next == eff_len) begin
                    hop_cnt_next = eff_hop;
                    trigger      = 1'b1;
                end
            end else if (hop_cnt_reg <= wfc_pkg::LEN_W'(1)) begin
                hop_cnt_next = eff_hop;
                trigger      = 1'b1;
            end else begin
                hop_cnt_next = hop_cnt_reg - 1'b1;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        start_next = start_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        cmd        = '0;

        cmd.ring_waddr   = wp_reg;
        cmd.ring_raddr   = start_reg + n_reg[wfc_pkg::RING_AW-1:0];
        cmd.weight_raddr = n_reg[wfc_pkg::RING_AW-1:0];
        cmd.freq         = k_reg;
        cmd.last         = last_k;

        case (state_reg)
            ST_IDLE: begin
                cmd.ring_we   = is_sample;
                cmd.weight_we = accept && (s_operation == wfc_pkg::OP_WEIGHT);
                cmd.inc_we    = accept && (s_operation == wfc_pkg::OP_INC) &&
                                (s_table_index < 10'(wfc_pkg::MAX_FREQUENCIES));
                if (trigger) begin
                    start_next = wp_next - eff_len[wfc_pkg::RING_AW-1:0];
                    k_next     = '0;
                    state_next = ST_INC_RD;
                end
            end
            ST_INC_RD: begin
                state_next = ST_INC_LD;
            end
            ST_INC_LD: begin
                cmd.inc_load = 1'b1;
                n_next       = '0;
                state_next   = ST_RUN;
            end
            ST_RUN: begin
                cmd.step = 1'b1;
                n_next   = n_reg + 1'b1;
                if (n_next == eff_len) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!status.busy) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                cmd.result_load = 1'b1;
                state_next      = ST_OUT;
            end
            ST_OUT: begin
                if (m_ready) begin
                    if (last_k) begin
                        state_next = ST_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        state_next = ST_INC_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            window_reg  <= wfc_pkg::WINDOW_RESET;
            hop_reg     <= wfc_pkg::HOP_RESET;
            freqs_reg   <= wfc_pkg::FREQS_RESET;
            wp_reg      <= '0;
            seen_reg    <= '0;
            hop_cnt_reg <= '0;
            start_reg   <= '0;
            n_reg       <= '0;
            k_reg       <= '0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            seen_reg    <= seen_next;
            hop_cnt_reg <= hop_cnt_next;
            start_reg   <= start_next;
            n_reg       <= n_next;
            k_reg       <= k_next;
            if (cfg_valid) begin
                case (cfg_index)
                    wfc_pkg::CFG_WINDOW: window_reg <= cfg_data;
                    wfc_pkg::CFG_HOP:    hop_reg    <= cfg_data;
                    wfc_pkg::CFG_FREQS:  freqs_reg  <= cfg_data[wfc_pkg::FCNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

FILE: design/windowed_fourier_coefficients.sv
// Top level of the windowed Fourier coefficient block.
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    operation, table_index, sample, table_value
//  m_        out        m_valid / m_ready    frequency_index, real_part, imag_part, last
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Table writes and samples that start no frame leave the block idle and ready.
// A frame runs, per frequency, on the single MAC pipeline: increment fetch,
// MAC over the window, drain, round, then the result transaction is held
// until taken; the whole frame repeats this for each of the nf frequencies.
// s_ready stays low from the frame-starting sample until the last result
// transaction. Reset (aresetn, synchronous) clears counters and config to
// defaults; memories are not cleared. cfg_ready is always high.
module windowed_fourier_coefficients (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_operation,
    input  logic [9:0]         s_table_index,
    input  logic signed [15:0] s_sample,
    input  logic [31:0]        s_table_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_frequency_index,
    output logic signed [31:0] m_real_part,
    output logic signed [31:0] m_imag_part,
    output logic               m_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [10:0]        cfg_data
);

    wfc_pkg::cmd_t    cmd;
    wfc_pkg::status_t status;

    // Sequencer: counting, trigger, per-frequency loop.
    wfc_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_table_index (s_table_index),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .status        (status)
    );

    // Memories, trig lookup, two-stage multiply, accumulate and round.
    wfc_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .s_table_index     (s_table_index),
        .s_sample          (s_sample),
        .s_table_value     (s_table_value),
        .m_frequency_index (m_frequency_index),
        .m_real_part       (m_real_part),
        .m_imag_part       (m_imag_part),
        .m_last            (m_last)
    );

endmodule

FILE: design/wfc_checker.sv
// Port-level checks for the windowed Fourier block, bound to the top level.
module wfc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [5:0]  m_frequency_index,
    input logic [31:0] m_real_part,
    input logic        m_last
);

    // No new input while a result is pending.
    a_no_input_during_output: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready) else $error("input ready while result pending");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frequency_index) && $stable(m_real_part))
        else $error("result changed while stalled");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid && s_ready)
        else $error("block not idle after last result");

    a_more_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> !s_ready && !m_valid)
        else $error("frame ended without last");

endmodule

bind windowed_fourier_coefficients wfc_checker u_wfc_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .s_ready           (s_ready),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_frequency_index (m_frequency_index),
    .m_real_part       (m_real_part),
    .m_last            (m_last)
);

FILE: verif/tb.sv
// Testbench for windowed_fourier_coefficients: self-checking, queue-fed driver and monitor.
`timescale 1ns / 100ps

module tb;

    localparam int WATCHDOG_LIMIT = 60000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WEIGHTS_LOADED = 16;

    typedef struct {
        wfc_pkg::op_t       op;
        logic [9:0]         idx;
        logic signed [15:0] smp;
        logic [31:0]        val;
    } stim_item_t;

    typedef struct {
        logic [5:0]         freq;
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic               last;
    } coef_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_operation;
    logic [9:0]         s_table_index;
    logic signed [15:0] s_sample;
    logic [31:0]        s_table_value;
    logic               m_valid;
    logic               m_ready;
    logic [5:0]         m_frequency_index;
    logic signed [31:0] m_real_part;
    logic signed [31:0] m_imag_part;
    logic               m_last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [10:0]        cfg_data;

    windowed_fourier_coefficients dut (.*);

    // clock: 20 ns period
    always begin
        aclk = 1'b1;
        #10;
        aclk = 1'b0;
        #10;
    end

    // ---------------------------------------------------------------------
    // Predictor state: its own copy of registers, tables, ring and counters
    // ---------------------------------------------------------------------
    logic [10:0]        win_reg, hop_reg;
    logic [6:0]         nf_reg;
    logic signed [15:0] ring [wfc_pkg::MAX_WINDOW];
    logic [15:0]        weights [wfc_pkg::MAX_WINDOW];
    logic [31:0]        incs [wfc_pkg::MAX_FREQUENCIES];
    int unsigned        wr_ptr, seen, hop_left;

    stim_item_t pending_items[$];
    coef_t      expected_coefs[$];

    int  send_idle_pct, recv_idle_pct;
    int  hold_off_cycles;
    bit  s_taken;
    int  mismatches;
    int  idle_cycles;

    // Q15 sine of a 32-bit cycle fraction, quarter-wave polynomial at 256 steps per quarter
    function automatic longint sine_of_phase(logic [31:0] phase);
        logic [9:0] ti;
        longint k, u, u2, t, s, r;
        ti = phase[31:22];
        k  = longint'(ti[7:0]);
        if (ti[8]) begin
            k = 256 - k;
        end
        u  = k <<< 22;
        u2 = (u * u) >>> 30;
        t  = 64'sd5026995 - ((u2 * 64'sd172272) >>> 30);
        t  = 64'sd85569306 - ((u2 * t) >>> 30);
        t  = 64'sd693598668 - ((u2 * t) >>> 30);
        t  = 64'sd1686629713 - ((u2 * t) >>> 30);
        s  = (u * t) >>> 30;
        r  = (s + 64'sd16384) >>> 15;
        if (r > 32768) begin
            r = 32768;
        end
        return ti[9] ? -r : r;
    endfunction

    // accumulator to Q15, round half up, saturate to 32 bits
    function automatic logic signed [31:0] to_q15(longint acc);
        longint v;
        v = (acc + (64'sd1 <<< 29)) >>> 30;
        if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end
        return 32'(v);
    endfunction

    function automatic int unsigned eff_window();
        if (win_reg == 0) begin
            return 1;
        end
        return (win_reg > wfc_pkg::MAX_WINDOW) ? wfc_pkg::MAX_WINDOW : {21'd0, win_reg};
    endfunction

    function automatic int unsigned eff_hop();
        return (hop_reg == 0) ? 1 : {21'd0, hop_reg};
    endfunction

    // queue one coefficient per active frequency for the current window
    task automatic predict_frame();
        int unsigned len, nf, start, pos;
        longint      acc_re, acc_im, xw;
        logic [31:0] phase;
        coef_t       c;
        len   = eff_window();
        nf    = (nf_reg == 0) ? 1 : ((nf_reg > wfc_pkg::MAX_FREQUENCIES) ?
                                     wfc_pkg::MAX_FREQUENCIES : {25'd0, nf_reg});
        start = (wr_ptr + wfc_pkg::MAX_WINDOW - len) % wfc_pkg::MAX_WINDOW;
        for (int k = 0; k < nf; k++) begin
            acc_re = 0;
            acc_im = 0;
            phase  = 0;
            pos    = start;
            for (int n = 0; n < len; n++) begin
                xw     = longint'(ring[pos]) * longint'({1'b0, weights[n]});
                acc_re += xw * sine_of_phase(phase + 32'h4000_0000);
                acc_im += xw * sine_of_phase(phase);
                phase  += incs[k];
                pos    = (pos + 1) % wfc_pkg::MAX_WINDOW;
            end
            c.freq = 6'(k);
            c.re   = to_q15(acc_re);
            c.im   = to_q15(acc_im);
            c.last = (k + 1 == nf);
            expected_coefs.push_back(c);
        end
    endtask

    task automatic predict_transaction(stim_item_t it);
        case (it.op)
            wfc_pkg::OP_WEIGHT: begin
                weights[it.idx] = (it.val > 32'd65535) ? 16'hFFFF : it.val[15:0];
            end
            wfc_pkg::OP_INC: begin
                if (it.idx < wfc_pkg::MAX_FREQUENCIES) begin
                    incs[it.idx] = it.val;
                end
            end
            wfc_pkg::OP_SAMPLE: begin
                ring[wr_ptr] = it.smp;
                wr_ptr = (wr_ptr + 1) % wfc_pkg::MAX_WINDOW;
                if (seen < eff_window()) begin
                    seen++;
                    if (seen == eff_window()) begin
                        hop_left = eff_hop();
                        predict_frame();
                    end
                end else if (hop_left <= 1) begin
                    hop_left = eff_hop();
                    predict_frame();
                end else begin
                    hop_left--;
                end
            end
            default: ;  // unknown operation: no effect
        endcase
    endtask

    // ---------------------------------------------------------------------
    // Monitor: everything sampled at the rising edge
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin
        stim_item_t it;
        coef_t      c;
        bit         fired;
        fired   = 1'b0;
        s_taken = s_valid && s_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                fired = 1'b1;
                case (wfc_pkg::cfg_idx_t'(cfg_index))
                    wfc_pkg::CFG_WINDOW: win_reg = cfg_data;
                    wfc_pkg::CFG_HOP:    hop_reg = cfg_data;
                    wfc_pkg::CFG_FREQS:  nf_reg  = cfg_data[6:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                fired  = 1'b1;
                it.op  = wfc_pkg::op_t'(s_operation);
                it.idx = s_table_index;
                it.smp = s_sample;
                it.val = s_table_value;
                predict_transaction(it);
            end
            if (m_valid && m_ready) begin
                fired = 1'b1;
                if (expected_coefs.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result transaction: freq %0d re %0d im %0d",
                                 m_frequency_index, m_real_part, m_imag_part);
                    end
                end else begin
                    c = expected_coefs.pop_front();
                    if (c.freq !== m_frequency_index || c.re !== m_real_part ||
                        c.im !== m_imag_part || c.last !== m_last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("result mismatch: exp f%0d re %0d im %0d last %0b",
                                     c.freq, c.re, c.im, c.last);
                            $display("                 got f%0d re %0d im %0d last %0b",
                                     m_frequency_index, m_real_part, m_imag_part, m_last);
                        end
                    end
                end
            end
            // watchdog: cycles in a row with no transaction anywhere
            idle_cycles = fired ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("windowed_fourier_coefficients: mismatch");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Driver: input channel, changes at the falling edge
    // ---------------------------------------------------------------------
    always @(negedge aclk) begin
        stim_item_t it;
        if (aresetn && !(s_valid && !s_taken)) begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                it            = pending_items.pop_front();
                s_valid       <= 1'b1;
                s_operation   <= it.op;
                s_table_index <= it.idx;
                s_sample      <= it.smp;
                s_table_value <= it.val;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result channel back-pressure, with an optional long hold-off
    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    task automatic push_item(wfc_pkg::op_t op, logic [9:0] idx, logic signed [15:0] smp,
                             logic [31:0] val);
        stim_item_t it;
        it.op  = op;
        it.idx = idx;
        it.smp = smp;
        it.val = val;
        pending_items.push_back(it);
    endtask

    task automatic push_samples(int count);
        for (int i = 0; i < count; i++) begin
            push_item(wfc_pkg::OP_SAMPLE, 10'($urandom), 16'($urandom), $urandom);
        end
    endtask

    // all results in and the block quiet
    task automatic wait_drained();
        while (pending_items.size() > 0 || s_valid || expected_coefs.size() > 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(wfc_pkg::cfg_idx_t idx, logic [10:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(logic [10:0] win, logic [10:0] hop, logic [10:0] nf);
        wait_drained();
        write_reg(wfc_pkg::CFG_WINDOW, win);
        write_reg(wfc_pkg::CFG_HOP, hop);
        write_reg(wfc_pkg::CFG_FREQS, nf);
    endtask

    // idling pattern picked by phase number
    task automatic set_idling(int phase_no);
        case (phase_no % 4)
            0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            1: begin send_idle_pct = 47; recv_idle_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_idle_pct = 47; end
            default: begin send_idle_pct = 20; recv_idle_pct = 20; end
        endcase
    endtask

    initial begin
        int r;
        aresetn         = 1'b0;
        s_valid         = 1'b0;
        s_operation     = wfc_pkg::OP_SAMPLE;
        s_table_index   = '0;
        s_sample        = '0;
        s_table_value   = '0;
        m_ready         = 1'b0;
        cfg_valid       = 1'b0;
        cfg_index       = wfc_pkg::CFG_WINDOW;
        cfg_data        = '0;
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        hold_off_cycles = 0;
        s_taken         = 1'b0;
        mismatches      = 0;
        idle_cycles     = 0;
        win_reg         = wfc_pkg::WINDOW_RESET;
        hop_reg         = wfc_pkg::HOP_RESET;
        nf_reg          = wfc_pkg::FREQS_RESET;
        wr_ptr          = 0;
        seen            = 0;
        hop_left        = 0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // small window first so no frame fires while the tables load
        configure(11'd4, 11'd2, 11'd3);

        // load the weights any window below reads, and every increment
        for (int i = 0; i < WEIGHTS_LOADED; i++) begin
            push_item(wfc_pkg::OP_WEIGHT, 10'(i), '0, 32'($urandom_range(32768)));
        end
        for (int i = 0; i < wfc_pkg::MAX_FREQUENCIES; i++) begin
            push_item(wfc_pkg::OP_INC, 10'(i), '0, $urandom);
        end
        wait_drained();

        // directed: table extremes, ignored writes, unknown op, sample extremes
        push_item(wfc_pkg::OP_WEIGHT, 10'd0, '0, 32'hFFFF_FFFF);   // saturates to 65535
        push_item(wfc_pkg::OP_WEIGHT, 10'd1, '0, 32'd65535);
        push_item(wfc_pkg::OP_WEIGHT, 10'd2, '0, 32'd0);
        push_item(wfc_pkg::OP_WEIGHT, 10'd1023, '0, 32'd32768);
        push_item(wfc_pkg::OP_INC, 10'd0, '0, 32'd0);
        push_item(wfc_pkg::OP_INC, 10'd1, '0, 32'hFFFF_FFFF);
        push_item(wfc_pkg::OP_INC, 10'd2, '0, 32'h4000_0000);
        push_item(wfc_pkg::OP_INC, 10'd64, '0, $urandom);          // index out of range
        push_item(wfc_pkg::OP_INC, 10'd1023, '0, $urandom);        // index out of range
        push_item(wfc_pkg::op_t'(2'd3), 10'h3FF, 16'sh7FFF, 32'hFFFF_FFFF);  // unknown op
        push_item(wfc_pkg::OP_SAMPLE, '0, 16'sh7FFF, '0);
        push_item(wfc_pkg::OP_SAMPLE, '0, -16'sd32768, '0);
        push_item(wfc_pkg::OP_SAMPLE, '0, 16'sh7FFF, '0);
        push_item(wfc_pkg::OP_SAMPLE, '0, -16'sd32768, '0);        // first full window
        push_item(wfc_pkg::OP_SAMPLE, '0, 16'sd0, '0);
        push_item(wfc_pkg::OP_SAMPLE, '0, -16'sd1, '0);            // next hop
        wait_drained();

        // register clamps at the low end: window 1, hop 1, one frequency
        configure(11'd0, 11'd0, 11'd0);
        push_samples(6);

        // window enlarged mid-stream, all 64 frequencies via clamp
        configure(11'd16, 11'd5, 11'd127);
        push_samples(22);
        wait_drained();

        // back-pressure: receiver holds off while the sender keeps offering
        configure(11'd4, 11'd1, 11'd2);
        hold_off_cycles = 3000;
        push_samples(30);

        // random phases: mostly samples with small windows, some table traffic and unknown ops
        for (int ph = 0; ph < 4; ph++) begin
            configure(11'($urandom_range(1, 12)), 11'($urandom_range(1, 6)),
                      11'($urandom_range(1, 8)));
            set_idling(ph);
            for (int i = 0; i < 16; i++) begin
                r = $urandom_range(99);
                if (r < 80) begin
                    push_samples(1);
                end else if (r < 88) begin
                    push_item(wfc_pkg::OP_WEIGHT, 10'($urandom), 16'($urandom),
                              ($urandom_range(3) == 0) ? $urandom
                                                       : 32'($urandom_range(65536)));
                end else if (r < 95) begin
                    push_item(wfc_pkg::OP_INC, 10'($urandom_range(63)), 16'($urandom),
                              $urandom);
                end else begin
                    push_item(wfc_pkg::op_t'(2'd3), 10'($urandom), 16'($urandom), $urandom);
                end
                // sender pause until every result is in
                if (ph == 3 && i == 8) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (mismatches == 0) begin
            $display("windowed_fourier_coefficients: match");
        end else begin
            $display("windowed_fourier_coefficients: mismatch");
        end
        $finish;
    end

endmodule
